@@ src/mhrr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mhrr_pkg;

    // widths fixed by the largest supported capacity (65536 entries, 17 levels)
    localparam int VAL_W = 64;
    localparam int POS_W = 16;
    localparam int IDX_W = 18;
    localparam int LEV_W = 5;

    // register selects (decoded on paddr[3] only)
    localparam logic REG_HEAP_SIZE  = 1'b0;
    localparam logic REG_FILL_VALUE = 1'b1;

    // sifted value travelling down the row of level cells
    typedef struct packed {
        logic                    valid;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } tok_t;

    // write into one level, issued by the level below it
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } wr_t;

    // sweep write broadcast to every level
    typedef struct packed {
        logic                    valid;
        logic [LEV_W-1:0]        level;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } clr_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SIFT,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ src/mhrr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mhrr_cell
    import mhrr_pkg::*;
#(
    parameter int LEVEL = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] n_used,
    input  wire tok_t             tok_in,
    input  wire wr_t              upw_in,
    input  wire clr_t             clr_in,
    output tok_t                  tok_out,
    output wr_t                   upw_out
);

    localparam int AW    = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int DEPTH = 1 << AW;
    localparam logic [IDX_W-1:0] BASE = IDX_W'((1 << LEVEL) - 1);

    // sibling pairs of this level, left and right child in separate banks
    logic signed [VAL_W-1:0] mem_l [DEPTH];
    logic signed [VAL_W-1:0] mem_r [DEPTH];

    logic signed [VAL_W-1:0] rd_l_reg;
    logic signed [VAL_W-1:0] rd_r_reg;
    logic [AW-1:0]           rd_addr;

    logic                    clr_hit;
    logic                    wr_en;
    logic [POS_W-1:0]        wr_pos;
    logic signed [VAL_W-1:0] wr_val;
    logic [AW-1:0]           wr_row;

    logic                    stg_valid_reg;
    logic signed [VAL_W-1:0] stg_value_reg;
    logic [POS_W-1:0]        stg_pos_reg;

    logic [IDX_W-1:0]        l_idx;
    logic [IDX_W-1:0]        r_idx;
    logic                    l_ok;
    logic                    r_ok;
    logic                    swap;
    logic                    side;
    logic signed [VAL_W-1:0] best_val;

    logic                    tok_valid_reg;
    logic signed [VAL_W-1:0] tok_value_reg;
    logic [POS_W-1:0]        tok_pos_reg;

    // write source select: move-up from the level below, or sweep
    always_comb
    begin
        clr_hit = clr_in.valid && (clr_in.level == LEV_W'(LEVEL));
        wr_en   = upw_in.valid || clr_hit;
        wr_pos  = upw_in.valid ? upw_in.pos : clr_in.pos;
        wr_val  = upw_in.valid ? upw_in.value : clr_in.value;
        wr_row  = wr_pos[AW:1];
        rd_addr = tok_in.pos[AW-1:0];
    end

    // left bank
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_pos[0])
        begin
            mem_l[wr_row] <= wr_val;
        end
        rd_l_reg <= mem_l[rd_addr];
    end

    // right bank
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_pos[0])
        begin
            mem_r[wr_row] <= wr_val;
        end
        rd_r_reg <= mem_r[rd_addr];
    end

    // hold the sifted value while the children are read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_value_reg <= tok_in.value;
        stg_pos_reg   <= tok_in.pos;
    end

    // pick the smaller child; ties keep the parent, left wins over right
    always_comb
    begin
        l_idx    = BASE + IDX_W'({stg_pos_reg, 1'b0});
        r_idx    = l_idx + IDX_W'(1);
        l_ok     = l_idx < n_used;
        r_ok     = r_idx < n_used;
        best_val = stg_value_reg;
        swap     = 1'b0;
        side     = 1'b0;
        if (l_ok && (rd_l_reg < best_val))
        begin
            best_val = rd_l_reg;
            swap     = 1'b1;
            side     = 1'b0;
        end
        if (r_ok && (rd_r_reg < best_val))
        begin
            best_val = rd_r_reg;
            swap     = 1'b1;
            side     = 1'b1;
        end
    end

    // parent slot gets the child on a swap, else the sifted value settles
    always_comb
    begin
        upw_out.valid = stg_valid_reg;
        upw_out.last  = !swap;
        upw_out.pos   = stg_pos_reg;
        upw_out.value = swap ? best_val : stg_value_reg;
    end

    // pass the sifted value on to the next level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= stg_valid_reg && swap;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_value_reg <= stg_value_reg;
        tok_pos_reg   <= {stg_pos_reg[POS_W-2:0], side};
    end

    assign tok_out = '{valid: tok_valid_reg, pos: tok_pos_reg, value: tok_value_reg};

endmodule

`default_nettype wire

@@ src/min_heap_replace_root.sv @@
// Binary min-heap of signed 64-bit values for top-k selection.
// Input stream: s_tdata carries new_value, s_tuser carries req_type
// (0 replace the root, 1 clear every entry in use to fill_value).
// Output stream: m_tdata carries popped_min (low half) and current_min
// (high half); exactly one output transaction per input transaction.
// Configuration through the APB port: heap_size at 0x0, fill_value at 0x8.
// The heap is a row of level cells below the root register; each holds its
// level in two banks of sibling entries. A replace walks the sifted value down
// the row, at each level a bank read, then a compare and move-up write; the
// walk ends early when the value settles. A clear writes one entry per cycle
// over the entries in use. The next transaction can be taken in the cycle
// after the result is loaded.
// One item is in work at a time; s_tready is high while the block is idle,
// also while a finished result waits in the output register.
// When the receiver stalls, the finished result stays in the output register
// and the next one waits in the block until that register is taken.
// After reset a clearing pass writes zero to all CAPACITY entries, one per
// cycle; s_tready stays low until the pass is done.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_replace_root
    import mhrr_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // new_value [63:0]
    input  wire logic         s_tuser,   // req_type [0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // popped_min [63:0], current_min [127:64]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [10:0]             heap_size_reg;
    logic                    size_full_reg;
    logic signed [VAL_W-1:0] fill_value_reg;
    logic [IDX_W-1:0]        n_reg;
    logic [IDX_W-1:0]        n_next;
    logic [IDX_W-1:0]        hs_ext;
    logic                    cfg_wr;

    logic signed [VAL_W-1:0] root_reg;
    logic signed [VAL_W-1:0] popped_reg;

    logic                    start_valid_reg;
    logic signed [VAL_W-1:0] start_value_reg;

    logic [IDX_W-1:0]        sw_cnt_reg;
    logic [LEV_W-1:0]        sw_lvl_reg;
    logic [POS_W-1:0]        sw_pos_reg;
    logic signed [VAL_W-1:0] sw_value_reg;
    logic [IDX_W-1:0]        sw_end;
    logic                    sw_last;
    logic                    sw_active;
    logic [POS_W-1:0]        lvl_mask;

    logic                    accept;
    logic                    out_load;
    logic                    sift_end;

    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] out_pop_reg;
    logic signed [VAL_W-1:0] out_cur_reg;

    tok_t tok [0:LEVELS-1];
    wr_t  upw [0:LEVELS-1];
    clr_t clr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_FILL_VALUE) ? fill_value_reg
                                                 : {53'd0, heap_size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg  <= 11'(CAPACITY);
            size_full_reg  <= 1'b1;
            fill_value_reg <= '0;
            n_reg          <= CAP;
        end
        else
        begin
            if (cfg_wr && (paddr[3] == REG_HEAP_SIZE))
            begin
                heap_size_reg <= pwdata[10:0];
                size_full_reg <= 1'b0;
            end
            if (cfg_wr && (paddr[3] == REG_FILL_VALUE))
            begin
                fill_value_reg <= pwdata;
            end
            n_reg <= n_next;
        end
    end

    // entries in use, clamped to 1..CAPACITY
    always_comb
    begin
        hs_ext = IDX_W'(heap_size_reg);
        if (size_full_reg || (hs_ext > CAP))
        begin
            n_next = CAP;
        end
        else if (hs_ext == '0)
        begin
            n_next = IDX_W'(1);
        end
        else
        begin
            n_next = hs_ext;
        end
    end

    // sweep over entries, level by level
    always_comb
    begin
        sw_active = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        sw_end    = (state_reg == ST_INIT) ? CAP : n_reg;
        sw_last   = (sw_cnt_reg == (sw_end - IDX_W'(1)));
        lvl_mask  = POS_W'((32'd1 << sw_lvl_reg) - 32'd1);
        clr       = '{valid: sw_active, level: sw_lvl_reg, pos: sw_pos_reg,
                      value: sw_value_reg};
    end

    // settle detection from any level
    always_comb
    begin
        sift_end = 1'b0;
        for (int k = 0; k < LEVELS; k++)
        begin
            sift_end = sift_end | (upw[k].valid & upw[k].last);
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                if (sw_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_CLEAR : ST_SIFT;
                end
            end
            ST_SIFT:
            begin
                if (sift_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                if (sw_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sweep counters and start token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cnt_reg      <= '0;
            sw_lvl_reg      <= '0;
            sw_pos_reg      <= '0;
            sw_value_reg    <= '0;
            start_valid_reg <= 1'b0;
        end
        else
        begin
            start_valid_reg <= accept && !s_tuser;
            if (accept && s_tuser)
            begin
                sw_cnt_reg   <= '0;
                sw_lvl_reg   <= '0;
                sw_pos_reg   <= '0;
                sw_value_reg <= fill_value_reg;
            end
            else if (sw_active)
            begin
                sw_cnt_reg <= sw_cnt_reg + IDX_W'(1);
                if (sw_pos_reg == lvl_mask)
                begin
                    sw_lvl_reg <= sw_lvl_reg + LEV_W'(1);
                    sw_pos_reg <= '0;
                end
                else
                begin
                    sw_pos_reg <= sw_pos_reg + POS_W'(1);
                end
            end
        end
    end

    // payload captured at acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_value_reg <= s_tdata;
            popped_reg      <= s_tuser ? '0 : root_reg;
        end
    end

    // root entry
    always_ff @(posedge clk)
    begin
        if (upw[0].valid)
        begin
            root_reg <= upw[0].value;
        end
        else if (clr.valid && (clr.level == '0))
        begin
            root_reg <= clr.value;
        end
    end

    // level cells; the deepest token settles in the deepest level
    assign tok[0] = '{valid: start_valid_reg, pos: '0, value: start_value_reg};
    assign upw[LEVELS-1] = '{valid: tok[LEVELS-1].valid, last: 1'b1,
                             pos: tok[LEVELS-1].pos, value: tok[LEVELS-1].value};

    for (genvar k = 1; k < LEVELS; k++)
    begin : g_cell
        mhrr_cell #(
            .LEVEL (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .n_used  (n_reg),
            .tok_in  (tok[k-1]),
            .upw_in  (upw[k]),
            .clr_in  (clr),
            .tok_out (tok[k]),
            .upw_out (upw[k-1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pop_reg <= popped_reg;
            out_cur_reg <= root_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_cur_reg, out_pop_reg};

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mhrr_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PRINT_CAP = 100;

    // request kinds carried in s_tuser
    localparam logic REQ_REPLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // row kinds of the directed table
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG = 1'b1;

    localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] popped;
        logic [63:0] current;
    } heap_result_t;

    // sel is the request kind for items and the register index for writes
    typedef struct packed {
        logic        kind;
        logic        sel;
        logic [63:0] data;
        logic        known;
        logic [63:0] exp_popped;
        logic [63:0] exp_current;
    } stim_row_t;

    localparam int NUM_ROWS = 27;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // fresh heap is all zero at full size
        '{ROW_ITEM, REQ_REPLACE, MAXV, 1'b1, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, MINV, 1'b1, 64'd0, MINV},
        '{ROW_ITEM, REQ_REPLACE, 64'd5, 1'b1, MINV, 64'd0},
        // full-size clear to the most negative fill
        '{ROW_CFG, REG_FILL_VALUE, MINV, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_CLEAR, 64'd0, 1'b1, 64'd0, MINV},
        // single entry heap
        '{ROW_CFG, REG_HEAP_SIZE, 64'd1, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, MAXV, 1'b1, MINV, MAXV},
        '{ROW_ITEM, REQ_REPLACE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, MAXV,
          64'hFFFF_FFFF_FFFF_FFFF},
        // size zero behaves as one
        '{ROW_CFG, REG_HEAP_SIZE, 64'd0, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7},
        // size above capacity clamps, no clear in between
        '{ROW_CFG, REG_HEAP_SIZE, 64'd2047, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_FILL_VALUE, MAXV, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_CLEAR, 64'h1234_5678_9ABC_DEF0, 1'b1, 64'd0, MAXV},
        // shrink and change fill without clear, old contents stay
        '{ROW_CFG, REG_HEAP_SIZE, 64'd3, 1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_FILL_VALUE, 64'd10, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'd1, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_CLEAR, MAXV, 1'b1, 64'd0, 64'd10},
        // parent tie stays, child tie takes the left one
        '{ROW_ITEM, REQ_REPLACE, 64'd10, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'd20, 1'b0, 64'd0, 64'd0},
        // grow without clear, stale entries join the heap
        '{ROW_CFG, REG_HEAP_SIZE, 64'd5, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'd11, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, MINV, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'd0, 1'b0, 64'd0, 64'd0},
        // upper write bits beyond the size field are dropped
        '{ROW_CFG, REG_HEAP_SIZE, 64'hFFFF_FFFF_FFFF_F802, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_REPLACE, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, 64'd0, 64'd0},
        '{ROW_ITEM, REQ_CLEAR, 64'd0, 1'b0, 64'd0, 64'd0}
    };

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // new_value [63:0]
    logic         s_tuser;   // req_type [0]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // popped_min [63:0], current_min [127:64]
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    // shadow copy of the heap and its registers
    logic signed [63:0] shadow_heap [CAPACITY];
    logic [10:0]        shadow_size;
    logic signed [63:0] shadow_fill;

    heap_result_t pending_results [$];
    int           error_count = 0;
    int           result_count = 0;
    int           cycle_count = 0;
    bit           idling_on = 1'b1;

    min_heap_replace_root #(.CAPACITY(CAPACITY)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic int entries_in_use();
        int n;
        n = int'(shadow_size);
        if (n == 0)
            n = 1;
        if (n > CAPACITY)
            n = CAPACITY;
        return n;
    endfunction

    // replace-and-sift or clear on the shadow heap
    function automatic heap_result_t apply_heap_request(input logic req,
                                                        input logic signed [63:0] val);
        heap_result_t       res;
        int                 n;
        int                 pos;
        int                 best;
        bit                 settled;
        logic signed [63:0] tmp;
        n = entries_in_use();
        res.popped = '0;
        if (req == REQ_CLEAR)
        begin
            for (int i = 0; i < n; i++)
                shadow_heap[i] = shadow_fill;
        end
        else
        begin
            res.popped = shadow_heap[0];
            shadow_heap[0] = val;
            pos = 0;
            settled = 1'b0;
            while (!settled)
            begin
                best = pos;
                if (2 * pos + 1 < n && shadow_heap[2 * pos + 1] < shadow_heap[best])
                    best = 2 * pos + 1;
                if (2 * pos + 2 < n && shadow_heap[2 * pos + 2] < shadow_heap[best])
                    best = 2 * pos + 2;
                if (best == pos)
                    settled = 1'b1;
                else
                begin
                    tmp = shadow_heap[pos];
                    shadow_heap[pos] = shadow_heap[best];
                    shadow_heap[best] = tmp;
                    pos = best;
                end
            end
        end
        res.current = shadow_heap[0];
        return res;
    endfunction

    // one input transaction; returns at the accepting edge with valid still high
    task automatic send_item(input logic req, input logic [63:0] val, input logic known,
                             input logic [63:0] kpop, input logic [63:0] kcur);
        int           gap;
        heap_result_t res;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = apply_heap_request(req, val);
        if (known)
        begin
            res.popped = kpop;
            res.current = kcur;
        end
        pending_results.push_back(res);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write, setup then access cycle
    task automatic write_register(input logic reg_idx, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 3'b000};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_idx == REG_HEAP_SIZE)
            shadow_size = data[10:0];
        else
            shadow_fill = data;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_value();
        logic signed [63:0] v;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = {$urandom, $urandom};
        else if (sel < 7)
        begin
            // narrow band so ties are common
            v = 64'($urandom_range(0, 8));
            v = v - 64'sd4;
        end
        else if (sel == 7)
            v = $urandom_range(0, 1) ? MAXV : MINV;
        else if (sel == 8)
            v = shadow_fill;
        else
            v = $urandom_range(0, 1) ? shadow_fill + 64'sd1 : shadow_fill - 64'sd1;
        return v;
    endfunction

    function automatic logic [63:0] pick_size();
        int          sel;
        logic [31:0] low_word;
        sel = $urandom_range(0, 15);
        low_word = $urandom;
        case (sel)
            0: return 64'd0;
            1: return 64'd1;
            2: return {$urandom, low_word[31:11], 11'h7FF};
            3: return 64'd1024;
            4: return {$urandom, $urandom};
            default: return 64'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [63:0] pick_fill();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return MINV;
            1: return MAXV;
            2: return 64'd0;
            3: return {$urandom, $urandom};
            default: return pick_value();
        endcase
    endfunction

    // result side
    initial
    begin
        heap_result_t exp;
        int           stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idling_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d with nothing pending", result_count));
            else
            begin
                exp = pending_results.pop_front();
                if (m_tdata[63:0] !== exp.popped)
                    report_mismatch($sformatf("result %0d popped_min %h, want %h",
                                              result_count, m_tdata[63:0], exp.popped));
                if (m_tdata[127:64] !== exp.current)
                    report_mismatch($sformatf("result %0d current_min %h, want %h",
                                              result_count, m_tdata[127:64], exp.current));
            end
        end
    end

    // stimulus
    initial
    begin
        int   sent;
        int   burst;
        int   cfg_sel;
        logic req;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= REQ_REPLACE;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_heap[i] = '0;
        shadow_size = 11'(CAPACITY);
        shadow_fill = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // wait out the clearing pass after reset
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                drain_results();
                write_register(DIRECTED[r].sel, DIRECTED[r].data);
            end
            else
                send_item(DIRECTED[r].sel, DIRECTED[r].data, DIRECTED[r].known,
                          DIRECTED[r].exp_popped, DIRECTED[r].exp_current);
        end

        // random phases, each with its own register setting
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            idling_on = ($urandom_range(0, 3) != 0);
            cfg_sel = $urandom_range(0, 2);
            if (cfg_sel != 1)
                write_register(REG_HEAP_SIZE, pick_size());
            if (cfg_sel != 0)
                write_register(REG_FILL_VALUE, pick_fill());
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(REQ_CLEAR, {$urandom, $urandom}, 1'b0, '0, '0);
                sent++;
            end
            burst = $urandom_range(10, 60);
            for (int k = 0; k < burst; k++)
            begin
                req = ($urandom_range(0, 29) == 0) ? REQ_CLEAR : REQ_REPLACE;
                send_item(req, req == REQ_CLEAR ? {$urandom, $urandom} : pick_value(),
                          1'b0, '0, '0);
                sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ min_heap_replace_root.f @@
src/mhrr_pkg.sv
src/mhrr_cell.sv
src/min_heap_replace_root.sv
bench/testbench.sv
